[hw/rtl/eiu_pkg.sv]
// Eased interpolation unit: shared package.
// Holds curve codes, the sideband beat type, polynomial tables and the Q2.30 product.
// Depends on nothing.
`default_nettype none

package eiu_pkg;

   localparam int FracBitsDef = 16;

   typedef enum logic [3:0] {
      CurveLinear     = 4'd0,
      CurveSineIn     = 4'd1,
      CurveSineOut    = 4'd2,
      CurveSineInOut  = 4'd3,
      CurveInQuad     = 4'd4,
      CurveOutQuad    = 4'd5,
      CurveInOutQuad  = 4'd6,
      CurveInCubic    = 4'd7,
      CurveOutCubic   = 4'd8,
      CurveInOutCubic = 4'd9,
      CurveOutElastic = 4'd10,
      CurveOutBounce  = 4'd11,
      CurveInBack     = 4'd12,
      CurveOutBack    = 4'd13
   } curve_type;

   typedef struct packed {
      logic signed [31:0] start_value;
      logic signed [31:0] end_value;
      logic [3:0]         curve;
      logic               done;
   } side_type;

   localparam logic signed [32:0] SinCoef [0:4] = '{
      33'sd1686629713, -33'sd693598668, 33'sd85569306, -33'sd5026994, 33'sd172272
   };

   localparam logic signed [32:0] ExpCoef [0:7] = '{
      33'sd1073741824, -33'sd1073741824, 33'sd536870912, -33'sd178956971,
      33'sd44739243, -33'sd8947849, 33'sd1491308, -33'sd213044
   };

   localparam logic signed [31:0] Ln2Q30    = 32'sd744261118;
   localparam logic [31:0]        Div3Magic = 32'h5555_5556;

   // floor(a * b / 2^30)
   function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                input logic signed [31:0] b);
      logic signed [64:0] pr;
      pr = a * b;
      return pr[62:30];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/eased_interpolation_unit_core.sv]
// Eased interpolation unit: top level, progress divider, easing pipeline, lerp.
// Depends on eiu_pkg, eiu_div and eiu_ease.
//
//   channel  handshake          payload
//   req      req_valid/ready    elapsed_ms, length_ms, start_value, end_value, curve
//   rsp      rsp_valid/ready    value, done_res
//
// One beat per cycle in and out while the result is not stalled.
// Pipeline depth is set by the divider (one quotient bit per stage) and the sine/exp Horner chains.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module eased_interpolation_unit_core #(
   parameter int PROGRESS_FRAC_BITS = eiu_pkg::FracBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_elapsed_ms,
   input  logic [31:0]        req_length_ms,
   input  logic signed [31:0] req_start_value,
   input  logic signed [31:0] req_end_value,
   input  logic [3:0]         req_curve,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic               rsp_done_res
);

   localparam int F  = PROGRESS_FRAC_BITS;
   localparam int EW = F + 3;
   localparam int PW = 33 + EW;

   logic                    adv;
   eiu_pkg::side_type       req_side;
   logic                    div_valid;
   logic [F:0]              div_t;
   eiu_pkg::side_type       div_side;
   logic                    ease_valid;
   logic signed [EW-1:0]    ease_e;
   eiu_pkg::side_type       ease_side;

   logic                    m1_valid_ff;
   logic signed [PW-1:0]    m1_prod_ff;
   logic signed [PW-1:0]    m1_prod_in;
   eiu_pkg::side_type       m1_side_ff;
   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_value_ff;
   logic signed [31:0]      rsp_value_in;
   logic                    rsp_done_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      req_side.start_value = req_start_value;
      req_side.end_value   = req_end_value;
      req_side.curve       = req_curve;
      req_side.done        = 1'b0;
   end

   eiu_div #(.FracBits(F)) u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_elapsed  (req_elapsed_ms),
      .in_duration (req_length_ms),
      .in_side     (req_side),
      .out_valid   (div_valid),
      .out_t       (div_t),
      .out_side    (div_side)
   );

   eiu_ease #(.FracBits(F)) u_ease (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_t      (div_t),
      .in_side   (div_side),
      .out_valid (ease_valid),
      .out_e     (ease_e),
      .out_side  (ease_side)
   );

   always_comb begin
      logic signed [32:0] diff;
      logic signed [PW-F+1:0] acc;
      diff       = 33'(ease_side.end_value) - 33'(ease_side.start_value);
      m1_prod_in = PW'(diff) * PW'(ease_e);
      acc = (PW-F+2)'(m1_side_ff.start_value) + (PW-F+2)'(m1_prod_ff >>> F);
      if (acc > (PW-F+2)'(32'sh7FFF_FFFF)) rsp_value_in = 32'sh7FFF_FFFF;
      else if (acc < -(PW-F+2)'(33'sh0_8000_0000)) rsp_value_in = 32'sh8000_0000;
      else rsp_value_in = acc[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff  <= ease_valid;
         rsp_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_prod_ff   <= m1_prod_in;
         m1_side_ff   <= ease_side;
         rsp_value_ff <= rsp_value_in;
         rsp_done_ff  <= m1_side_ff.done;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_done_res = rsp_done_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_lerp_advance: assert property (@(posedge clock) disable iff (reset)
      m1_valid_ff && adv |=> rsp_valid_ff)
      else $error("product stage beat lost");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(m1_prod_ff) && $stable(m1_valid_ff))
      else $error("product stage moved during stall");

endmodule

`default_nettype wire

[hw/rtl/eiu_div.sv]
// Eased interpolation unit: pipelined restoring divider for progress.
// One quotient bit per stage; clamps to one when elapsed reaches duration.
// Depends on eiu_pkg.
`default_nettype none

module eiu_div #(
   parameter int FracBits = eiu_pkg::FracBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [31:0]        in_elapsed,
   input  logic [31:0]        in_duration,
   input  eiu_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [FracBits:0]  out_t,
   output eiu_pkg::side_type  out_side
);

   localparam logic [FracBits:0] OneT = (FracBits+1)'(1) << FracBits;

   logic                    valid_ff [0:FracBits];
   logic                    valid_in [0:FracBits];
   logic [31:0]             rem_ff   [0:FracBits];
   logic [31:0]             rem_in   [0:FracBits];
   logic [31:0]             du_ff    [0:FracBits];
   logic [31:0]             du_in    [0:FracBits];
   logic [FracBits-1:0]     q_ff     [0:FracBits];
   logic [FracBits-1:0]     q_in     [0:FracBits];
   eiu_pkg::side_type       side_ff  [0:FracBits];
   eiu_pkg::side_type       side_in  [0:FracBits];

   always_comb begin
      logic [32:0] r2;
      logic        ge;
      valid_in[0]     = in_valid;
      rem_in[0]       = in_elapsed;
      du_in[0]        = in_duration;
      q_in[0]         = '0;
      side_in[0]      = in_side;
      side_in[0].done = (in_elapsed >= in_duration);
      for (int k = 1; k <= FracBits; k++) begin
         r2          = {rem_ff[k-1], 1'b0};
         ge          = (r2 >= {1'b0, du_ff[k-1]});
         r2          = ge ? (r2 - {1'b0, du_ff[k-1]}) : r2;
         valid_in[k] = valid_ff[k-1];
         rem_in[k]   = r2[31:0];
         du_in[k]    = du_ff[k-1];
         q_in[k]     = {q_ff[k-1][FracBits-2:0], ge};
         side_in[k]  = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FracBits; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= FracBits; k++) valid_ff[k] <= valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= FracBits; k++) begin
            rem_ff[k]  <= rem_in[k];
            du_ff[k]   <= du_in[k];
            q_ff[k]    <= q_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[FracBits];
   assign out_side  = side_ff[FracBits];
   assign out_t     = side_ff[FracBits].done ? OneT : {1'b0, q_ff[FracBits]};

endmodule

`default_nettype wire

[hw/rtl/eiu_ease.sv]
// Eased interpolation unit: easing curve pipeline, progress to eased progress.
// Twelve stages: operand setup, sine and exp Horner chains, final select.
// Depends on eiu_pkg.
`default_nettype none

module eiu_ease #(
   parameter int FracBits = eiu_pkg::FracBitsDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [FracBits:0]        in_t,
   input  eiu_pkg::side_type        in_side,
   output logic                     out_valid,
   output logic signed [FracBits+2:0] out_e,
   output eiu_pkg::side_type        out_side
);

   localparam int TW = FracBits + 1;
   localparam int EW = FracBits + 3;
   localparam int NS = 12;

   localparam logic [TW-1:0]      OneT  = TW'(1) << FracBits;
   localparam logic [TW-1:0]      HalfT = OneT >> 1;
   localparam logic signed [31:0] One32 = 32'sd1 <<< FracBits;
   localparam longint             BackSL = ((longint'(170158) << FracBits) + 50000) / 100000;
   localparam logic signed [31:0] BackS = 32'(BackSL);
   localparam logic signed [31:0] BackK = BackS + One32;
   localparam logic [TW+3:0]      Bnd4  = (TW+4)'(4) << FracBits;
   localparam logic [TW+3:0]      Bnd8  = (TW+4)'(8) << FracBits;
   localparam logic [TW+3:0]      Bnd10 = (TW+4)'(10) << FracBits;
   localparam logic [TW+4:0]      Nine  = (TW+5)'(9) << FracBits;

   typedef struct packed {
      logic                    valid;
      eiu_pkg::side_type       side;
      logic [TW-1:0]           t;
      logic                    lo;
      logic                    le;
      logic signed [31:0]      x1;
      logic signed [31:0]      y1;
      logic [TW-1:0]           badd;
      logic [FracBits+5:0]     q3;
      logic [3:0]              npow;
      logic [30:0]             f30;
      logic [30:0]             x30;
      logic                    sneg;
      logic signed [31:0]      u;
      logic signed [31:0]      v;
      logic signed [31:0]      w;
      logic [30:0]             x2;
      logic [30:0]             ey;
      logic signed [32:0]      sp;
      logic signed [32:0]      ep;
      logic [TW-1:0]           s;
      logic [TW-1:0]           pw;
      logic signed [EW-1:0]    e;
   } work_type;

   work_type w_ff [0:NS-1];
   work_type w_in [0:NS-1];
   logic     valid_ff [0:NS-1];

   function automatic logic signed [31:0] mulf(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] pr;
      pr = a * b;
      return pr[FracBits+31:FracBits];
   endfunction

   // operand setup
   always_comb begin
      logic signed [31:0]       ts;
      logic [TW+3:0]            t11;
      logic [TW+3:0]            e10;
      logic [TW+4:0]            n40;
      logic [FracBits+37:0]     mq;
      logic signed [31:0]       eb;
      w_in[0]       = w_ff[0];
      w_in[0].valid = in_valid;
      w_in[0].side  = in_side;
      w_in[0].t     = in_t;
      w_in[0].lo    = (in_t < HalfT);
      w_in[0].le    = (in_t <= HalfT);
      ts  = $signed(32'(in_t));
      t11 = (TW+4)'(in_t) * (TW+4)'(11);
      if (t11 < Bnd4) begin
         eb = 32'(22) * ts;
         w_in[0].badd = '0;
      end else if (t11 < Bnd8) begin
         eb = 32'(22) * ts - 32'(12) * One32;
         w_in[0].badd = TW'(3) * (OneT >> 2);
      end else if (t11 < Bnd10) begin
         eb = 32'(22) * ts - 32'(18) * One32;
         w_in[0].badd = TW'(15) * (OneT >> 4);
      end else begin
         eb = 32'(22) * ts - 32'(21) * One32;
         w_in[0].badd = TW'(63) * (OneT >> 6);
      end
      w_in[0].x1 = ts;
      w_in[0].y1 = ts;
      case (eiu_pkg::curve_type'(in_side.curve))
         eiu_pkg::CurveOutQuad: begin
            w_in[0].y1 = 32'(2) * One32 - ts;
         end
         eiu_pkg::CurveInOutQuad: begin
            if (!(in_t < HalfT)) w_in[0].x1 = 32'(4) * One32 - 32'(2) * ts;
         end
         eiu_pkg::CurveOutCubic, eiu_pkg::CurveOutBack: begin
            w_in[0].x1 = ts - One32;
            w_in[0].y1 = ts - One32;
         end
         eiu_pkg::CurveInOutCubic: begin
            if (!(in_t < HalfT)) begin
               w_in[0].x1 = 32'(2) * ts - 32'(2) * One32;
               w_in[0].y1 = 32'(2) * ts - 32'(2) * One32;
            end
         end
         eiu_pkg::CurveOutBounce: begin
            w_in[0].x1 = eb;
            w_in[0].y1 = eb;
         end
         default: begin
         end
      endcase
      e10 = (TW+4)'(in_t) * (TW+4)'(10);
      w_in[0].npow = e10[FracBits+3:FracBits];
      w_in[0].f30  = 31'({e10[FracBits-1:0], {(30-FracBits){1'b0}}});
      n40 = (TW+5)'(in_t) * (TW+5)'(40) + Nine;
      mq  = (FracBits+38)'(n40) * (FracBits+38)'(eiu_pkg::Div3Magic);
      w_in[0].q3 = mq[FracBits+37:32];
   end

   // sine argument, first products
   always_comb begin
      logic [FracBits+1:0] m;
      logic [TW-1:0]       fr;
      logic [TW:0]         t2;
      logic [TW:0]         sx;
      logic signed [31:0]  vs;
      w_in[1]       = w_ff[0];
      w_in[1].valid = valid_ff[0];
      m  = w_ff[0].q3[FracBits+1:0];
      fr = {1'b0, m[FracBits-1:0]};
      t2 = {w_ff[0].t, 1'b0};
      sx = (TW+1)'(w_ff[0].t);
      w_in[1].sneg = 1'b0;
      case (eiu_pkg::curve_type'(w_ff[0].side.curve))
         eiu_pkg::CurveSineIn: sx = (TW+1)'(OneT - w_ff[0].t);
         eiu_pkg::CurveSineInOut: begin
            sx = w_ff[0].le ? ((TW+1)'(OneT) - t2) : (t2 - (TW+1)'(OneT));
            w_in[1].sneg = !w_ff[0].le;
         end
         eiu_pkg::CurveOutElastic: begin
            sx = m[FracBits] ? (TW+1)'(OneT - fr) : (TW+1)'(fr);
            w_in[1].sneg = m[FracBits+1];
         end
         default: begin
         end
      endcase
      w_in[1].x30 = 31'({sx[TW-1:0], {(30-FracBits){1'b0}}});
      vs = (eiu_pkg::curve_type'(w_ff[0].side.curve) == eiu_pkg::CurveOutBack) ? BackS : -BackS;
      w_in[1].u = mulf(w_ff[0].x1, w_ff[0].y1);
      w_in[1].v = mulf(BackK, w_ff[0].x1) + vs;
   end

   // sine square and exp argument for the polynomials, second poly product
   always_comb begin
      logic signed [32:0] r;
      logic               back;
      w_in[2]       = w_ff[1];
      w_in[2].valid = valid_ff[1];
      r = eiu_pkg::mul30($signed({2'b00, w_ff[1].x30}), $signed({1'b0, w_ff[1].x30}));
      w_in[2].x2 = r[30:0];
      r = eiu_pkg::mul30($signed({2'b00, w_ff[1].f30}), eiu_pkg::Ln2Q30);
      w_in[2].ey = r[30:0];
      back = (eiu_pkg::curve_type'(w_ff[1].side.curve) == eiu_pkg::CurveInBack) ||
             (eiu_pkg::curve_type'(w_ff[1].side.curve) == eiu_pkg::CurveOutBack);
      w_in[2].w = mulf(w_ff[1].u, back ? w_ff[1].v : w_ff[1].x1);
   end

   // Horner steps, sine finish, exp shift, final select
   always_comb begin
      logic signed [64:0]    pr;
      logic signed [64:0]    ps;
      logic [5:0]            sh;
      logic signed [32:0]    pe;
      logic signed [TW:0]    ss;
      logic signed [31:0]    ex;
      logic signed [31:0]    te;
      for (int k = 3; k < NS; k++) begin
         w_in[k]       = w_ff[k-1];
         w_in[k].valid = valid_ff[k-1];
      end
      for (int k = 3; k <= 6; k++) begin
         w_in[k].sp = eiu_pkg::SinCoef[6-k] +
                      eiu_pkg::mul30((k == 3) ? eiu_pkg::SinCoef[4] : w_ff[k-1].sp,
                                     $signed({1'b0, w_ff[k-1].x2}));
      end
      for (int k = 3; k <= 9; k++) begin
         w_in[k].ep = eiu_pkg::ExpCoef[9-k] +
                      eiu_pkg::mul30((k == 3) ? eiu_pkg::ExpCoef[7] : w_ff[k-1].ep,
                                     $signed({1'b0, w_ff[k-1].ey}));
      end
      pr = w_ff[6].sp * $signed({1'b0, w_ff[6].x30});
      ps = pr >>> (60 - FracBits);
      if (pr < 0) w_in[7].s = '0;
      else if (ps > 65'(OneT)) w_in[7].s = OneT;
      else w_in[7].s = ps[TW-1:0];
      sh = 6'(w_ff[9].npow) + 6'(30 - FracBits);
      pe = w_ff[9].ep >>> sh;
      w_in[10].pw = pe[TW-1:0];
      ss = w_ff[10].sneg ? -$signed({1'b0, w_ff[10].s}) : $signed({1'b0, w_ff[10].s});
      te = $signed(32'(w_ff[10].t));
      case (eiu_pkg::curve_type'(w_ff[10].side.curve))
         eiu_pkg::CurveSineIn:     ex = One32 - $signed(32'(w_ff[10].s));
         eiu_pkg::CurveSineOut:    ex = $signed(32'(w_ff[10].s));
         eiu_pkg::CurveSineInOut:  ex = (One32 - 32'(ss)) >>> 1;
         eiu_pkg::CurveInQuad,
         eiu_pkg::CurveOutQuad:    ex = w_ff[10].u;
         eiu_pkg::CurveInOutQuad:  ex = w_ff[10].lo ? (w_ff[10].u <<< 1) : (w_ff[10].u - One32);
         eiu_pkg::CurveInCubic,
         eiu_pkg::CurveInBack:     ex = w_ff[10].w;
         eiu_pkg::CurveOutCubic,
         eiu_pkg::CurveOutBack:    ex = w_ff[10].w + One32;
         eiu_pkg::CurveInOutCubic: begin
            ex = w_ff[10].lo ? (w_ff[10].w <<< 2) : ((w_ff[10].w >>> 1) + One32);
         end
         eiu_pkg::CurveOutElastic: begin
            if (w_ff[10].t == '0 || w_ff[10].t == OneT) ex = te;
            else ex = mulf($signed(32'(w_ff[10].pw)), 32'(ss)) + One32;
         end
         eiu_pkg::CurveOutBounce:  ex = (w_ff[10].u >>> 6) + $signed(32'(w_ff[10].badd));
         default:                  ex = te;
      endcase
      w_in[11].e = ex[EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) valid_ff[k] <= w_in[k].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) w_ff[k] <= w_in[k];
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_e     = w_ff[NS-1].e;
   assign out_side  = w_ff[NS-1].side;

endmodule

`default_nettype wire

[tb/eased_interpolation_unit_core_tb.sv]
// Testbench for eased_interpolation_unit_core: directed table, then random beats with bursty
// sender and stalling receiver, checked against an in-bench easing/lerp predictor.
// Depends on eiu_pkg and the core RTL.
`default_nettype none

module eased_interpolation_unit_core_tb;

   localparam int FB = eiu_pkg::FracBitsDef;
   localparam longint ONE = longint'(1) << FB;
   localparam longint HALF = longint'(1) << (FB - 1);
   localparam logic [3:0] CurveSpareLo = 4'd14;
   localparam logic [3:0] CurveSpareHi = 4'd15;
   localparam int NumRandom = 1400;
   localparam int IdleLimit = 5000;
   localparam int Latency = FB + 15;

   typedef struct {
      logic [31:0]        elapsed;
      logic [31:0]        duration;
      logic signed [31:0] start_v;
      logic signed [31:0] end_v;
      logic [3:0]         curve;
      bit                 fixed;
      logic signed [31:0] value;
      logic               done;
   } stim_row_type;

   typedef struct {
      logic signed [31:0] value;
      logic               done;
   } lerp_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_elapsed_ms = '0;
   logic [31:0]        req_length_ms = '0;
   logic signed [31:0] req_start_value = '0;
   logic signed [31:0] req_end_value = '0;
   logic [3:0]         req_curve = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_done_res;

   lerp_result_type pending_results[$];
   int              errors = 0;
   int              idle_cycles = 0;

   always #1 clock = ~clock;

   eased_interpolation_unit_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_elapsed_ms(req_elapsed_ms), .req_length_ms(req_length_ms),
      .req_start_value(req_start_value), .req_end_value(req_end_value),
      .req_curve(req_curve),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_value(rsp_value), .rsp_done_res(rsp_done_res)
   );

   function automatic longint quarter_sine(longint x);
      longint x30, x2, p;
      x30 = x <<< (30 - FB);
      x2 = (x30 * x30) >>> 30;
      p = longint'(eiu_pkg::SinCoef[4]);
      for (int i = 3; i >= 0; i--) p = longint'(eiu_pkg::SinCoef[i]) + ((p * x2) >>> 30);
      p = ((p * x30) >>> 30) >>> (30 - FB);
      if (p < 0) p = 0;
      if (p > ONE) p = ONE;
      return p;
   endfunction

   function automatic longint turn_sine(longint q);
      longint m, quad, fr, s;
      m = q % (4 * ONE);
      quad = m >>> FB;
      fr = m & (ONE - 1);
      s = quad[0] ? quarter_sine(ONE - fr) : quarter_sine(fr);
      return (quad >= 2) ? -s : s;
   endfunction

   function automatic longint decay_pow2(longint t);
      longint e, f30, y, p;
      int n;
      e = 10 * t;
      n = int'(e >>> FB);
      f30 = (e & (ONE - 1)) <<< (30 - FB);
      y = (f30 * longint'(eiu_pkg::Ln2Q30)) >>> 30;
      p = longint'(eiu_pkg::ExpCoef[7]);
      for (int i = 6; i >= 0; i--) p = longint'(eiu_pkg::ExpCoef[i]) + ((p * y) >>> 30);
      return p >>> (n + 30 - FB);
   endfunction

   function automatic longint fx(longint a, longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic longint eased_progress(logic [3:0] c, longint t);
      longint f, cs, e, m, bs;
      bs = ((longint'(170158) << FB) + 50000) / 100000;
      case (c)
         eiu_pkg::CurveSineIn: return ONE - quarter_sine(ONE - t);
         eiu_pkg::CurveSineOut: return quarter_sine(t);
         eiu_pkg::CurveSineInOut: begin
            cs = (t <= HALF) ? quarter_sine(ONE - 2 * t) : -quarter_sine(2 * t - ONE);
            return (ONE - cs) >>> 1;
         end
         eiu_pkg::CurveInQuad: return fx(t, t);
         eiu_pkg::CurveOutQuad: return fx(t, 2 * ONE - t);
         eiu_pkg::CurveInOutQuad: begin
            if (t < HALF) return 2 * fx(t, t);
            return fx(4 * ONE - 2 * t, t) - ONE;
         end
         eiu_pkg::CurveInCubic: return fx(fx(t, t), t);
         eiu_pkg::CurveOutCubic: begin
            f = t - ONE;
            return fx(fx(f, f), f) + ONE;
         end
         eiu_pkg::CurveInOutCubic: begin
            if (t < HALF) return 4 * fx(fx(t, t), t);
            f = 2 * t - 2 * ONE;
            return (fx(fx(f, f), f) >>> 1) + ONE;
         end
         eiu_pkg::CurveOutElastic: begin
            if (t == 0 || t == ONE) return t;
            return fx(decay_pow2(t), turn_sine((40 * t + 9 * ONE) / 3)) + ONE;
         end
         eiu_pkg::CurveOutBounce: begin
            if (11 * t < 4 * ONE) begin
               m = 0; f = 0;
            end else if (11 * t < 8 * ONE) begin
               m = 12; f = 3 * (ONE >>> 2);
            end else if (11 * t < 10 * ONE) begin
               m = 18; f = 15 * (ONE >>> 4);
            end else begin
               m = 21; f = 63 * (ONE >>> 6);
            end
            e = 22 * t - m * ONE;
            return (fx(e, e) >>> 6) + f;
         end
         eiu_pkg::CurveInBack: return fx(fx(t, t), fx(bs + ONE, t) - bs);
         eiu_pkg::CurveOutBack: begin
            f = t - ONE;
            return fx(fx(f, f), fx(bs + ONE, f) + bs) + ONE;
         end
         default: return t;
      endcase
   endfunction

   function automatic lerp_result_type predict_lerp(logic [31:0] el, logic [31:0] du,
                                                    logic signed [31:0] sv,
                                                    logic signed [31:0] ev, logic [3:0] c);
      lerp_result_type r;
      longint t, e, v;
      if (du == 0 || el >= du) t = ONE;
      else t = longint'((longint'(el) << FB) / longint'(du));
      e = eased_progress(c, t);
      v = longint'(sv) + (((longint'(ev) - longint'(sv)) * e) >>> FB);
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) v = -64'sh8000_0000;
      r.value = v[31:0];
      r.done = (t == ONE);
      return r;
   endfunction

   localparam logic signed [31:0] VMin = 32'sh8000_0000;
   localparam logic signed [31:0] VMax = 32'sh7FFF_FFFF;

   stim_row_type directed[] = '{
      '{32'd0, 32'd0, 32'sd0, 32'sh10000, eiu_pkg::CurveLinear, 1'b1, 32'sh10000, 1'b1},
      '{32'd0, 32'd100, 32'sh1234, 32'sh50000, eiu_pkg::CurveLinear, 1'b1, 32'sh1234, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, VMin, VMax, eiu_pkg::CurveLinear, 1'b1, VMax, 1'b1},
      '{32'hFFFF_FFFF, 32'd1, VMax, VMin, eiu_pkg::CurveInCubic, 1'b1, VMin, 1'b1},
      '{32'd0, 32'hFFFF_FFFF, VMax, VMin, eiu_pkg::CurveSineIn, 1'b0, 32'sd0, 1'b0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, VMin, VMax, eiu_pkg::CurveSineOut, 1'b0, 32'sd0, 1'b0},
      '{32'd50, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveLinear, 1'b0, 32'sd0, 1'b0},
      '{32'd30, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveSineIn, 1'b0, 32'sd0, 1'b0},
      '{32'd30, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveSineOut, 1'b0, 32'sd0, 1'b0},
      '{32'd70, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveSineInOut, 1'b0, 32'sd0, 1'b0},
      '{32'd30, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveInQuad, 1'b0, 32'sd0, 1'b0},
      '{32'd30, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveOutQuad, 1'b0, 32'sd0, 1'b0},
      '{32'd70, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveInOutQuad, 1'b0, 32'sd0, 1'b0},
      '{32'd40, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveInOutCubic, 1'b0, 32'sd0, 1'b0},
      '{32'd60, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveOutCubic, 1'b0, 32'sd0, 1'b0},
      '{32'd7, 32'd100, 32'sd0, 32'sh10000, eiu_pkg::CurveOutElastic, 1'b0, 32'sd0, 1'b0},
      '{32'd0, 32'd10, 32'sd5, 32'sd100, eiu_pkg::CurveOutElastic, 1'b1, 32'sd5, 1'b0},
      '{32'd10, 32'd10, 32'sd5, 32'sd100, eiu_pkg::CurveOutElastic, 1'b1, 32'sd100, 1'b1},
      '{32'd4, 32'd11, 32'sd0, 32'sh10000, eiu_pkg::CurveOutBounce, 1'b0, 32'sd0, 1'b0},
      '{32'd8, 32'd11, 32'sd0, 32'sh10000, eiu_pkg::CurveOutBounce, 1'b0, 32'sd0, 1'b0},
      '{32'd10, 32'd11, 32'sd0, 32'sh10000, eiu_pkg::CurveOutBounce, 1'b0, 32'sd0, 1'b0},
      '{32'd20, 32'd100, VMin, VMax, eiu_pkg::CurveInBack, 1'b0, 32'sd0, 1'b0},
      '{32'd50, 32'd100, VMin, VMax, eiu_pkg::CurveOutBack, 1'b0, 32'sd0, 1'b0},
      '{32'd50, 32'd100, 32'sd0, 32'sh10000, CurveSpareLo, 1'b0, 32'sd0, 1'b0},
      '{32'd25, 32'd100, 32'sd0, 32'sh10000, CurveSpareHi, 1'b0, 32'sd0, 1'b0}
   };

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h40000) - 32'h20000;
         1: return $urandom_range(0, 1) ? VMax : VMin;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(stim_row_type r);
      lerp_result_type p;
      req_valid = 1'b1;
      req_elapsed_ms = r.elapsed;
      req_length_ms = r.duration;
      req_start_value = r.start_v;
      req_end_value = r.end_v;
      req_curve = r.curve;
      do @(posedge clock); while (!req_ready);
      p = predict_lerp(r.elapsed, r.duration, r.start_v, r.end_v, r.curve);
      if (r.fixed) begin
         p.value = r.value;
         p.done = r.done;
      end
      pending_results.push_back(p);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // receiver: stall mode is redrawn at random from four ready patterns
   int stall_mode = 0;
   int rx_cycle = 0;
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      lerp_result_type x;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected beat: value %0d done %0b", rsp_value, rsp_done_res);
               errors = errors + 1;
            end else begin
               x = pending_results.pop_front();
               if (rsp_value !== x.value) begin
                  $error("value: expected %0d, actual %0d", x.value, rsp_value);
                  errors = errors + 1;
               end
               if (rsp_done_res !== x.done) begin
                  $error("done_res: expected %0b, actual %0b", x.done, rsp_done_res);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   initial begin
      stim_row_type r;
      int burst;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) begin
         send_beat(directed[i]);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
      end
      burst = 0;
      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom / 2) begin
            req_valid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: r.duration = 32'd0;
            1, 2, 3: r.duration = $urandom_range(1, 1000);
            4, 5: r.duration = $urandom;
            default: r.duration = $urandom_range(1, 32'h00FF_FFFF);
         endcase
         case ($urandom_range(0, 9))
            0, 1: r.elapsed = $urandom;
            2: r.elapsed = r.duration + $urandom_range(0, 5);
            default: r.elapsed = (r.duration == 0) ? 32'd0 : $urandom_range(0, r.duration);
         endcase
         r.start_v = pick_value();
         r.end_v = pick_value();
         r.curve = $urandom_range(0, 15);
         r.fixed = 1'b0;
         send_beat(r);
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
         end else begin
            burst--;
         end
      end
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/eiu_pkg.sv
hw/rtl/eiu_div.sv
hw/rtl/eiu_ease.sv
hw/rtl/eased_interpolation_unit_core.sv
tb/eased_interpolation_unit_core_tb.sv
